/* rtl/hof_pkg.sv */
// hof_pkg: shared constants of the hampel outlier filter
// no dependencies; imported by hampel_outlier_filter
package hof_pkg;

    localparam int CFG_W       = 16;
    localparam int SCALE_SHIFT = 12;
    localparam logic [CFG_W-1:0] SCALE_RESET = 16'd18218;

endpackage

/* rtl/hampel_outlier_filter.sv */
// hampel_outlier_filter: streaming hampel filter over a window of 2*HALF_WIDTH+1 samples
// depends on hof_pkg, hof_win_cell, hof_rank_sel
//
// Takes one sample per clock while not held off by a flush or output back-pressure. Each
// result leaves six register stages after the push that completes its window (window
// capture, median ranks, deviations, MAD ranks, threshold product, output register).
// A result for sample i appears once sample i+HALF_WIDTH has arrived; windows before the
// first sample repeat it. After a transaction with tlast the input is held off while the
// window is flushed with HALF_WIDTH replicas of that sample, the last result carries
// tlast, and the next sample starts a fresh sequence. A result is flagged an outlier when
// |x - median| * 4096 > scale * MAD and is then replaced by the median.
module hampel_outlier_filter #(
    parameter int HALF_WIDTH  = 5,
    parameter int SAMPLE_BITS = 24,
    localparam int TDATA_W    = ((SAMPLE_BITS + 7) / 8) * 8
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [TDATA_W-1:0]         s_axis_tdata,  // sample
    input  logic                       s_axis_tlast,
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic [TDATA_W-1:0]         m_axis_tdata,  // filtered
    output logic                       m_axis_tlast,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [hof_pkg::CFG_W-1:0]  cfg_data
);

    import hof_pkg::*;

    localparam int WIN_LEN = 2 * HALF_WIDTH + 1;
    localparam int CNT_W   = $clog2(HALF_WIDTH + 1);
    localparam int PROD_W  = CFG_W + SAMPLE_BITS;

    // control
    logic                   seq_started_reg;
    logic [CNT_W-1:0]       prime_reg;
    logic [CNT_W-1:0]       flush_reg;
    logic [CFG_W-1:0]       scale_reg;

    logic                   accept;
    logic                   flush_step;
    logic                   push;
    logic                   fill;
    logic                   emit;
    logic                   flush_end;
    logic [CNT_W-1:0]       prime_inc;
    logic signed [SAMPLE_BITS-1:0] in_sample;
    logic signed [SAMPLE_BITS-1:0] push_val;

    // window cells
    logic [SAMPLE_BITS-1:0] win_q     [WIN_LEN];
    logic [SAMPLE_BITS-1:0] win_d     [WIN_LEN];
    logic [SAMPLE_BITS-1:0] shift_in  [WIN_LEN];

    // pipeline
    logic                   v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, vo_reg;
    logic                   rdy1, rdy2, rdy3, rdy4, rdy5, rdyo;
    logic                   last1_reg, last2_reg, last3_reg, last4_reg, last5_reg, lasto_reg;
    logic [SAMPLE_BITS-1:0] win1_reg  [WIN_LEN];
    logic [SAMPLE_BITS-1:0] win2_reg  [WIN_LEN];
    logic [SAMPLE_BITS-1:0] dev3_reg  [WIN_LEN];
    logic signed [SAMPLE_BITS-1:0] med2_reg, med3_reg, med4_reg, med5_reg;
    logic signed [SAMPLE_BITS-1:0] cen3_reg, cen4_reg, cen5_reg;
    logic [SAMPLE_BITS-1:0] mad4_reg, d4_reg;
    logic [PROD_W-1:0]      prod5_reg, dsh5_reg;
    logic [SAMPLE_BITS-1:0] out_reg;

    logic [WIN_LEN-1:0][SAMPLE_BITS-1:0] med_keys;
    logic [WIN_LEN-1:0][SAMPLE_BITS-1:0] dev_keys;
    logic [SAMPLE_BITS-1:0] med_sel;
    logic [SAMPLE_BITS-1:0] mad_sel;
    logic signed [SAMPLE_BITS-1:0] med_val;
    logic [SAMPLE_BITS-1:0] dev_val   [WIN_LEN];
    logic signed [SAMPLE_BITS:0]   diff [WIN_LEN];
    logic signed [SAMPLE_BITS:0]   adiff [WIN_LEN];

    assign in_sample  = s_axis_tdata[SAMPLE_BITS-1:0];
    assign rdyo       = !vo_reg || m_axis_tready;
    assign rdy5       = !v5_reg || rdyo;
    assign rdy4       = !v4_reg || rdy5;
    assign rdy3       = !v3_reg || rdy4;
    assign rdy2       = !v2_reg || rdy3;
    assign rdy1       = !v1_reg || rdy2;

    assign s_axis_tready = (flush_reg == '0) && rdy1;
    assign accept     = s_axis_tvalid && s_axis_tready;
    assign flush_step = (flush_reg != '0) && rdy1;
    assign push       = accept || flush_step;
    assign fill       = accept && !seq_started_reg;
    assign emit       = push && (prime_reg == CNT_W'(HALF_WIDTH));
    assign flush_end  = flush_step && (flush_reg == CNT_W'(1));
    assign prime_inc  = (prime_reg == CNT_W'(HALF_WIDTH)) ? prime_reg : prime_reg + CNT_W'(1);
    assign push_val   = flush_step ? signed'(win_q[WIN_LEN-1]) : in_sample;
    assign cfg_ready  = 1'b1;

    for (genvar g = 0; g < WIN_LEN; g++)
    begin : g_cell
        if (g == WIN_LEN - 1)
        begin : g_head
            assign shift_in[g] = push_val;
        end
        else
        begin : g_body
            assign shift_in[g] = win_q[g+1];
        end

        hof_win_cell #(
            .WIDTH (SAMPLE_BITS)
        ) u_cell (
            .clk       (clk),
            .fill      (fill),
            .shift     (push),
            .fill_val  (in_sample),
            .shift_in  (shift_in[g]),
            .cell_q    (win_q[g]),
            .cell_next (win_d[g])
        );

        // offset binary so the unsigned rank compare orders signed samples
        assign med_keys[g] = {~win1_reg[g][SAMPLE_BITS-1], win1_reg[g][SAMPLE_BITS-2:0]};
        assign dev_keys[g] = dev3_reg[g];
    end

    hof_rank_sel #(
        .COUNT (WIN_LEN),
        .RANK  (HALF_WIDTH),
        .WIDTH (SAMPLE_BITS)
    ) u_med_sel (
        .keys (med_keys),
        .sel  (med_sel)
    );

    hof_rank_sel #(
        .COUNT (WIN_LEN),
        .RANK  (HALF_WIDTH),
        .WIDTH (SAMPLE_BITS)
    ) u_mad_sel (
        .keys (dev_keys),
        .sel  (mad_sel)
    );

    assign med_val = signed'({~med_sel[SAMPLE_BITS-1], med_sel[SAMPLE_BITS-2:0]});

    always_comb
    begin
        for (int i = 0; i < WIN_LEN; i++)
        begin
            diff[i]    = {win2_reg[i][SAMPLE_BITS-1], win2_reg[i]}
                       - {med2_reg[SAMPLE_BITS-1], med2_reg};
            adiff[i]   = diff[i][SAMPLE_BITS] ? -diff[i] : diff[i];
            dev_val[i] = adiff[i][SAMPLE_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_started_reg <= 1'b0;
            prime_reg       <= '0;
            flush_reg       <= '0;
            scale_reg       <= SCALE_RESET;
            v1_reg          <= 1'b0;
            v2_reg          <= 1'b0;
            v3_reg          <= 1'b0;
            v4_reg          <= 1'b0;
            v5_reg          <= 1'b0;
            vo_reg          <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                scale_reg <= cfg_data;
            end
            if (accept)
            begin
                seq_started_reg <= 1'b1;
                prime_reg       <= prime_inc;
                if (s_axis_tlast)
                begin
                    flush_reg <= CNT_W'(HALF_WIDTH);
                end
            end
            else if (flush_step)
            begin
                flush_reg <= flush_reg - CNT_W'(1);
                if (flush_end)
                begin
                    prime_reg       <= '0;
                    seq_started_reg <= 1'b0;
                end
                else
                begin
                    prime_reg <= prime_inc;
                end
            end
            if (rdy1)
            begin
                v1_reg <= emit;
            end
            if (rdy2)
            begin
                v2_reg <= v1_reg;
            end
            if (rdy3)
            begin
                v3_reg <= v2_reg;
            end
            if (rdy4)
            begin
                v4_reg <= v3_reg;
            end
            if (rdy5)
            begin
                v5_reg <= v4_reg;
            end
            if (rdyo)
            begin
                vo_reg <= v5_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            win1_reg  <= win_d;
            last1_reg <= flush_end;
        end
        if (rdy2)
        begin
            win2_reg  <= win1_reg;
            med2_reg  <= med_val;
            last2_reg <= last1_reg;
        end
        if (rdy3)
        begin
            dev3_reg  <= dev_val;
            med3_reg  <= med2_reg;
            cen3_reg  <= signed'(win2_reg[HALF_WIDTH]);
            last3_reg <= last2_reg;
        end
        if (rdy4)
        begin
            mad4_reg  <= mad_sel;
            d4_reg    <= dev3_reg[HALF_WIDTH];
            med4_reg  <= med3_reg;
            cen4_reg  <= cen3_reg;
            last4_reg <= last3_reg;
        end
        if (rdy5)
        begin
            prod5_reg <= PROD_W'(scale_reg) * PROD_W'(mad4_reg);
            dsh5_reg  <= PROD_W'({d4_reg, {SCALE_SHIFT{1'b0}}});
            med5_reg  <= med4_reg;
            cen5_reg  <= cen4_reg;
            last5_reg <= last4_reg;
        end
        if (rdyo)
        begin
            out_reg   <= (dsh5_reg > prod5_reg) ? med5_reg : cen5_reg;
            lasto_reg <= last5_reg;
        end
    end

    assign m_axis_tvalid = vo_reg;
    assign m_axis_tdata  = TDATA_W'(out_reg);
    assign m_axis_tlast  = lasto_reg;

endmodule

/* rtl/hof_win_cell.sv */
// hof_win_cell: one sample slot of the window line, shifts from its newer neighbour
// no dependencies; instantiated by hampel_outlier_filter
module hof_win_cell #(
    parameter int WIDTH = 24
) (
    input  logic             clk,
    input  logic             fill,
    input  logic             shift,
    input  logic [WIDTH-1:0] fill_val,
    input  logic [WIDTH-1:0] shift_in,
    output logic [WIDTH-1:0] cell_q,
    output logic [WIDTH-1:0] cell_next
);

    logic [WIDTH-1:0] q_reg;
    logic [WIDTH-1:0] q_next;

    always_comb
    begin
        if (fill)
        begin
            q_next = fill_val;
        end
        else if (shift)
        begin
            q_next = shift_in;
        end
        else
        begin
            q_next = q_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
    end

    assign cell_q    = q_reg;
    assign cell_next = q_next;

endmodule

/* rtl/hof_rank_sel.sv */
// hof_rank_sel: parallel rank comparators, picks the key of a given rank (ties by position)
// no dependencies; instantiated by hampel_outlier_filter
module hof_rank_sel #(
    parameter int COUNT = 11,
    parameter int RANK  = 5,
    parameter int WIDTH = 24
) (
    input  logic [COUNT-1:0][WIDTH-1:0] keys,
    output logic [WIDTH-1:0]            sel
);

    localparam int RW = $clog2(COUNT);

    logic [RW-1:0] rank [COUNT];

    always_comb
    begin
        sel = '0;
        for (int i = 0; i < COUNT; i++)
        begin
            rank[i] = '0;
            for (int j = 0; j < COUNT; j++)
            begin
                if (j != i && (keys[j] < keys[i] || (keys[j] == keys[i] && j < i)))
                begin
                    rank[i] = rank[i] + RW'(1);
                end
            end
        end
        for (int i = 0; i < COUNT; i++)
        begin
            if (rank[i] == RW'(RANK))
            begin
                sel = sel | keys[i];
            end
        end
    end

endmodule

/* verif/hampel_outlier_filter_test.sv */
// hampel_outlier_filter_test: self-checking testbench for the streaming hampel outlier filter
// holds its own window model, checks every filtered result and tlast against it
// depends on hof_pkg and hampel_outlier_filter
module hampel_outlier_filter_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HALF = 5;
    localparam int WIN = 2 * HALF + 1;
    localparam int SW = 24;
    localparam int CW = hof_pkg::CFG_W;
    localparam int LIMIT_CYCLES = 300000;
    localparam int SETTLE = 24;

    typedef logic signed [SW-1:0] sample_t;
    typedef logic [SW:0] gap_t;
    typedef struct packed
    {
        sample_t filtered;
        logic    out_last;
    } filt_result_t;

    localparam sample_t S_MAX = 24'sh7FFFFF;
    localparam sample_t S_MIN = 24'sh800000;

    logic          clk;
    logic          rst_n;
    logic          s_axis_tvalid;
    logic          s_axis_tready;
    logic [SW-1:0] s_axis_tdata;   // sample
    logic          s_axis_tlast;
    logic          m_axis_tvalid;
    logic          m_axis_tready;
    logic [SW-1:0] m_axis_tdata;   // filtered
    logic          m_axis_tlast;
    logic          cfg_valid;
    logic          cfg_ready;
    logic [CW-1:0] cfg_data;

    sample_t       win_line [WIN];
    int unsigned   primed = 0;
    bit            seq_open = 1'b0;
    logic [CW-1:0] scale_q12 = hof_pkg::SCALE_RESET;
    filt_result_t  expected_filt [$];

    bit idle_en = 1'b1;
    int unsigned cycles = 0;
    int unsigned mismatches = 0;
    int unsigned results_checked = 0;
    int unsigned samples_sent = 0;
    int unsigned runs_sent = 0;
    int unsigned medians_swapped = 0;
    int unsigned scale_writes = 0;

    hampel_outlier_filter #(
        .HALF_WIDTH (HALF),
        .SAMPLE_BITS(SW)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tlast (s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic gap_t abs_gap(input sample_t a, input sample_t b);
        logic signed [SW+1:0] d;
        d = a - b;
        return (d < 0) ? gap_t'(-d) : gap_t'(d);
    endfunction

    function automatic void shift_in(input sample_t x);
        for (int i = 0; i < WIN - 1; i++)
            win_line[i] = win_line[i + 1];
        win_line[WIN - 1] = x;
    endfunction

    // median and MAD of the current window, then the outlier decision on the centre
    function automatic sample_t judge_window();
        sample_t srt [WIN];
        gap_t    dev [WIN];
        sample_t med;
        sample_t hold_s;
        gap_t    hold_d;
        gap_t    mad;
        gap_t    cen_gap;
        logic [40:0] lhs;
        logic [40:0] rhs;
        int j;
        srt = win_line;
        for (int i = 1; i < WIN; i++)
        begin
            hold_s = srt[i];
            for (j = i; j > 0 && srt[j - 1] > hold_s; j--)
                srt[j] = srt[j - 1];
            srt[j] = hold_s;
        end
        med = srt[HALF];
        for (int i = 0; i < WIN; i++)
            dev[i] = abs_gap(win_line[i], med);
        for (int i = 1; i < WIN; i++)
        begin
            hold_d = dev[i];
            for (j = i; j > 0 && dev[j - 1] > hold_d; j--)
                dev[j] = dev[j - 1];
            dev[j] = hold_d;
        end
        mad = dev[HALF];
        cen_gap = abs_gap(win_line[HALF], med);
        lhs = 41'(cen_gap) << hof_pkg::SCALE_SHIFT;
        rhs = 41'(scale_q12) * 41'(mad);
        if (lhs > rhs)
        begin
            if (med != win_line[HALF])
                medians_swapped++;
            return med;
        end
        return win_line[HALF];
    endfunction

    function automatic void predict_sample(input sample_t x, input logic lst);
        int unsigned prior;
        if (!seq_open)
        begin
            for (int i = 0; i < WIN; i++)
                win_line[i] = x;
            seq_open = 1'b1;
            primed = 0;
        end
        else
            shift_in(x);
        prior = primed;
        if (prior >= HALF)
            expected_filt.push_back('{filtered: judge_window(), out_last: 1'b0});
        if (primed < HALF)
            primed++;
        if (lst)
        begin
            // flush with replicas of the final sample
            for (int k = 1; k <= HALF; k++)
            begin
                shift_in(x);
                if (prior + k >= HALF)
                    expected_filt.push_back('{filtered: judge_window(), out_last: k == HALF});
            end
            for (int i = 0; i < WIN; i++)
                win_line[i] = '0;
            primed = 0;
            seq_open = 1'b0;
        end
    endfunction

    task automatic send_sample(input sample_t x, input logic lst);
        if (idle_en && $urandom_range(0, 5) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= x;
        s_axis_tlast <= lst;
        do @(posedge clk); while (!s_axis_tready);
        predict_sample(x, lst);
        samples_sent++;
        if (lst)
            runs_sent++;
    endtask

    task automatic send_run(input sample_t vals [$]);
        foreach (vals[i])
            send_sample(vals[i], i == vals.size() - 1);
    endtask

    task automatic drain_results(input int settle);
        s_axis_tvalid <= 1'b0;
        do @(posedge clk); while (expected_filt.size() != 0);
        repeat (settle) @(posedge clk);
    endtask

    task automatic write_scale(input logic [CW-1:0] v);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        scale_q12 = v;
        scale_writes++;
    endtask

    function automatic int pick_run_length();
        int r;
        r = $urandom_range(0, 9);
        if (r < 2)
            return $urandom_range(1, HALF);
        if (r < 9)
            return $urandom_range(HALF + 1, 40);
        return $urandom_range(41, 90);
    endfunction

    // noisy plateaus, ramps and flat runs with spikes, or plain full-range values
    task automatic send_random_run(input int len, input int pause_at);
        int mode;
        int spread;
        sample_t base;
        sample_t x;
        mode = $urandom_range(0, 3);
        base = sample_t'($urandom);
        spread = 1 << $urandom_range(0, 12);
        for (int i = 0; i < len; i++)
        begin
            if (i == pause_at)
                drain_results(0);
            case (mode)
                0: x = sample_t'($urandom);
                1: x = base + sample_t'($urandom_range(0, 2 * spread)) - sample_t'(spread);
                2: x = base;
                default: x = base + sample_t'(i * spread);
            endcase
            if (mode != 0 && $urandom_range(0, 7) == 0)
                x = sample_t'($urandom);
            send_sample(x, i == len - 1);
        end
    endtask

    task automatic send_random_items(input int total);
        int sent;
        int len;
        sent = 0;
        while (sent < total)
        begin
            len = pick_run_length();
            send_random_run(len, -1);
            sent += len;
        end
    endtask

    task automatic test_edge_cases();
        send_run('{S_MAX});
        send_run('{S_MIN, S_MAX});
        send_run('{sample_t'(0), sample_t'(0), S_MIN, sample_t'(0), sample_t'(0)});
        send_run('{sample_t'(0), sample_t'(-1), sample_t'(0), sample_t'(-1), sample_t'(0),
                   sample_t'(-1)});
        send_run('{sample_t'(256), sample_t'(256), sample_t'(256), S_MAX, sample_t'(256),
                   sample_t'(256), sample_t'(256), sample_t'(256), S_MIN});
        drain_results(SETTLE);
    endtask

    task automatic test_scale_extremes();
        logic [CW-1:0] scales [5];
        scales = '{16'd0, 16'hFFFF, CW'($urandom), 16'd1, hof_pkg::SCALE_RESET};
        foreach (scales[i])
        begin
            write_scale(scales[i]);
            send_random_items(30);
            drain_results(SETTLE);
        end
    endtask

    task automatic test_random_stream();
        // sender holds off mid-run until every pending result is out
        send_random_run(24, 12);
        send_random_items(150);
        drain_results(SETTLE);
    endtask

    task automatic test_unpaced_tail();
        idle_en = 1'b0;
        send_random_items(60);
    endtask

    initial
    begin : sink_pacing
        m_axis_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (idle_en && $urandom_range(0, 6) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin : result_check
        filt_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            results_checked++;
            if (expected_filt.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected transaction: filtered %0d tlast %0b",
                             $signed(m_axis_tdata), m_axis_tlast);
            end
            else
            begin
                want = expected_filt.pop_front();
                if (m_axis_tdata !== want.filtered || m_axis_tlast !== want.out_last)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result %0d: expected filtered %0d tlast %0b, got %0d tlast %0b",
                                 results_checked, $signed(want.filtered), want.out_last,
                                 $signed(m_axis_tdata), m_axis_tlast);
                end
            end
        end
    end

    always @(posedge clk)
    begin : watchdog
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("hampel_outlier_filter_test failed");
            $finish;
        end
    end

    initial
    begin : main_seq
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tlast = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        for (int i = 0; i < WIN; i++)
            win_line[i] = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_edge_cases();
        test_scale_extremes();
        test_random_stream();
        test_unpaced_tail();
        drain_results(SETTLE);
        $display("%0d samples in %0d runs, %0d results checked, %0d replaced by the median",
                 samples_sent, runs_sent, results_checked, medians_swapped);
        $display("%0d scale settings incl. 0 and 65535, random gaps and stalls except at the end",
                 scale_writes);
        if (mismatches == 0 && expected_filt.size() == 0)
            $display("hampel_outlier_filter_test passed");
        else
            $display("hampel_outlier_filter_test failed");
        $finish;
    end

endmodule
